// ----- src/fiht_pkg.sv -----
// Package for the flow id hash table: field widths, table geometry, command
// and status codes, and the word and record types shared by its importers.
// Depends on nothing.
package fiht_pkg;

   // Table geometry. BUCKETS must be a power of two, as the bucket is taken
   // from the low bits of the flow id.
   localparam int BUCKETS  = 1024;
   localparam int WAYS     = 4;
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int USED_W   = $clog2(WAYS + 1);

   // Field widths.
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int KEY_W    = 32;
   localparam int SIZE_W   = 16;
   localparam int IDX_W    = 16;
   localparam int TIME_W   = 64;
   localparam int COUNT_W  = 8;
   localparam int FLOWS_W  = 13;

   // Command codes; the unused code behaves as a search.
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   // One stored record with its key.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SIZE_W-1:0]  size;
      logic [IDX_W-1:0]   start;
      logic [IDX_W-1:0]   stop;
      logic [TIME_W-1:0]  stamp;
      logic [COUNT_W-1:0] count;
   } entry_type;

   // One bucket row: all ways side by side, way 0 the oldest.
   typedef entry_type [WAYS-1:0] row_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam int ROW_W   = $bits(row_type);

   // Request word as latched from the input channel.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  flow_id;
      logic [SIZE_W-1:0] pkt_len;
      logic [IDX_W-1:0]  start_index;
      logic [TIME_W-1:0] now_time;
   } req_word_type;

   // Response word as held in the output register.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SIZE_W-1:0]   rec_size;
      logic [IDX_W-1:0]    rec_start;
      logic [IDX_W-1:0]    rec_end;
      logic [TIME_W-1:0]   rec_time;
      logic [COUNT_W-1:0]  rec_count;
      logic [FLOWS_W-1:0]  flows_held;
   } rsp_word_type;

   // Write-back control from the bucket update logic.
   typedef struct packed {
      logic               we;
      logic [USED_W-1:0]  used;
      logic [FLOWS_W-1:0] total;
   } upd_type;

endpackage

// ----- src/fiht_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on fiht_pkg for the field widths.
interface fiht_req_if import fiht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [KEY_W-1:0]  flow_id;
   logic [SIZE_W-1:0] pkt_len;
   logic [IDX_W-1:0]  start_index;
   logic [TIME_W-1:0] now_time;

   modport source (output valid, cmd, flow_id, pkt_len, start_index, now_time,
                   input ready);
   modport sink (input valid, cmd, flow_id, pkt_len, start_index, now_time,
                 output ready);
endinterface

interface fiht_rsp_if import fiht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SIZE_W-1:0]   rec_size;
   logic [IDX_W-1:0]    rec_start;
   logic [IDX_W-1:0]    rec_end;
   logic [TIME_W-1:0]   rec_time;
   logic [COUNT_W-1:0]  rec_count;
   logic [FLOWS_W-1:0]  flows_held;

   modport source (output valid, status, rec_size, rec_start, rec_end, rec_time,
                   rec_count, flows_held, input ready);
   modport sink (input valid, status, rec_size, rec_start, rec_end, rec_time,
                 rec_count, flows_held, output ready);
endinterface

// ----- src/fiht_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read
// port. Depends on nothing.
module fiht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fiht_bucket_update.sv -----
// Bucket row update: compares all ways against the key, builds the row and
// way count to write back, and forms the response word.
// Depends on fiht_pkg.
module fiht_bucket_update import fiht_pkg::*; (
   input  req_word_type       req_word,
   input  row_type            row,
   input  logic [USED_W-1:0]  used,
   input  logic [FLOWS_W-1:0] total,
   output row_type            new_row,
   output upd_type            upd,
   output rsp_word_type       rsp_word
);

   logic              found;
   logic [WAY_W-1:0]  hit;
   entry_type         fresh;
   entry_type         hit_entry;
   logic              full;

   // Oldest way in use whose key matches.
   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && (USED_W'(w) < used) && (row[w].key == req_word.flow_id)) begin
            found = 1'b1;
            hit   = WAY_W'(w);
         end
      end
   end

   assign hit_entry = row[hit];
   assign full      = (used >= USED_W'(WAYS));

   // Record that an insert appends.
   always_comb begin
      fresh.key   = req_word.flow_id;
      fresh.size  = req_word.pkt_len;
      fresh.start = req_word.start_index;
      fresh.stop  = req_word.start_index;
      fresh.stamp = req_word.now_time;
      fresh.count = COUNT_W'(1);
   end

   // New row, way count, flow count and response.
   always_comb begin
      new_row   = row;
      upd.we    = 1'b0;
      upd.used  = used;
      upd.total = total;
      rsp_word  = '0;
      case (req_word.cmd)
         CMD_INSERT: begin
            if (full) begin
               rsp_word.status = STAT_FULL;
            end else begin
               for (int w = 0; w < WAYS; w++) begin
                  if (USED_W'(w) == used) begin
                     new_row[w] = fresh;
                  end
               end
               upd.we    = 1'b1;
               upd.used  = used + USED_W'(1);
               upd.total = total + FLOWS_W'(1);
               rsp_word.status    = STAT_OK;
               rsp_word.rec_size  = fresh.size;
               rsp_word.rec_start = fresh.start;
               rsp_word.rec_end   = fresh.stop;
               rsp_word.rec_time  = fresh.stamp;
               rsp_word.rec_count = fresh.count;
            end
         end
         default: begin
            if (!found) begin
               rsp_word.status = STAT_MISS;
            end else begin
               rsp_word.status    = STAT_OK;
               rsp_word.rec_size  = hit_entry.size;
               rsp_word.rec_start = hit_entry.start;
               rsp_word.rec_end   = hit_entry.stop;
               rsp_word.rec_time  = hit_entry.stamp;
               rsp_word.rec_count = hit_entry.count;
               if (req_word.cmd == CMD_REMOVE) begin
                  // Younger ways slide down one place to close the gap.
                  for (int w = 0; w < WAYS - 1; w++) begin
                     if (WAY_W'(w) >= hit) begin
                        new_row[w] = row[w + 1];
                     end
                  end
                  upd.we    = 1'b1;
                  upd.used  = used - USED_W'(1);
                  upd.total = total - FLOWS_W'(1);
               end
            end
         end
      endcase
      rsp_word.flows_held = upd.total;
   end

endmodule

// ----- src/flow_id_hash_table_unit.sv -----
// Flow id hash table, top level. An accepted request word is latched as its
// bucket row and way count are read, and its response is registered once the
// output register is free; no new word is accepted until then, due to the row
// read-modify-write. After reset a clearing pass over all BUCKETS (1024)
// buckets zeroes the way-count memory while no request is accepted. Depends on
// fiht_pkg, the channel interfaces, fiht_ram and fiht_bucket_update.
module flow_id_hash_table_unit import fiht_pkg::*; (
   input logic         clock,
   input logic         reset,
   fiht_req_if.sink    req_chan,
   fiht_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP
   } state_type;

   state_type          state_ff;
   logic [BUCKET_W-1:0] clear_addr_ff;
   req_word_type       req_word_ff;
   rsp_word_type       rsp_word_ff;
   logic               rsp_valid_ff;
   logic [FLOWS_W-1:0] flow_total_ff;

   logic               accept;
   logic               advance;
   logic [BUCKET_W-1:0] bucket;
   row_type            row_rd;
   logic [ROW_W-1:0]   row_rd_bits;
   logic [USED_W-1:0]  used_rd;
   row_type            new_row;
   upd_type            upd;
   rsp_word_type       rsp_word_in;
   logic               row_we;
   logic               used_we;
   logic [BUCKET_W-1:0] used_wr_addr;
   logic [USED_W-1:0]  used_wr_data;

   // Handshake and write-back control.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign advance        = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);
   assign bucket         = req_word_ff.flow_id[BUCKET_W-1:0];
   assign row_we         = advance && upd.we;
   assign used_we        = (state_ff == S_CLEAR) || row_we;
   assign used_wr_addr   = (state_ff == S_CLEAR) ? clear_addr_ff : bucket;
   assign used_wr_data   = (state_ff == S_CLEAR) ? '0 : upd.used;
   assign row_rd         = row_type'(row_rd_bits);

   // Bucket rows, undefined until written.
   fiht_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (bucket),
      .wr_data (ROW_W'(new_row)),
      .rd_en   (accept),
      .rd_addr (req_chan.flow_id[BUCKET_W-1:0]),
      .rd_data (row_rd_bits)
   );

   // Ways in use per bucket, zeroed by the clearing pass.
   fiht_ram #(
      .WIDTH (USED_W),
      .DEPTH (BUCKETS)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_wr_addr),
      .wr_data (used_wr_data),
      .rd_en   (accept),
      .rd_addr (req_chan.flow_id[BUCKET_W-1:0]),
      .rd_data (used_rd)
   );

   fiht_bucket_update u_update (
      .req_word (req_word_ff),
      .row      (row_rd),
      .used     (used_rd),
      .total    (flow_total_ff),
      .new_row  (new_row),
      .upd      (upd),
      .rsp_word (rsp_word_in)
   );

   // Sequencer, request latch, flow count and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         flow_total_ff <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clear_addr_ff <= clear_addr_ff + BUCKET_W'(1);
               if (clear_addr_ff == BUCKET_W'(BUCKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (advance) begin
                  state_ff      <= S_IDLE;
                  flow_total_ff <= upd.total;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         req_word_ff.cmd         <= req_chan.cmd;
         req_word_ff.flow_id     <= req_chan.flow_id;
         req_word_ff.pkt_len     <= req_chan.pkt_len;
         req_word_ff.start_index <= req_chan.start_index;
         req_word_ff.now_time    <= req_chan.now_time;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Response channel.
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_word_ff.status;
   assign rsp_chan.rec_size   = rsp_word_ff.rec_size;
   assign rsp_chan.rec_start  = rsp_word_ff.rec_start;
   assign rsp_chan.rec_end    = rsp_word_ff.rec_end;
   assign rsp_chan.rec_time   = rsp_word_ff.rec_time;
   assign rsp_chan.rec_count  = rsp_word_ff.rec_count;
   assign rsp_chan.flows_held = rsp_word_ff.flows_held;

   // An accepted word always goes on to its bucket lookup.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted word did not enter lookup");

   // The flow count moves only when a lookup completes.
   a_total_stable: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flow_total_ff))
      else $error("flow count changed outside a lookup");

   // A waiting response carries the current flow count.
   a_flows_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.flows_held == flow_total_ff))
      else $error("waiting response disagrees with flow count");

endmodule
